@@ design/ugci_pkg.sv @@
// Shared types, widths and helpers for the uniform grid cell indexer.
// Used by uniform_grid_cell_indexer; depends on nothing else.
package ugci_pkg;

   // Field and datapath widths
   localparam int FIX_W      = 32;   // signed Q16.16 positions
   localparam int EDGE_W     = 31;   // cell edge, unsigned Q15.16
   localparam int RECIP_W    = 32;   // reciprocal, unsigned Q16.16
   localparam int CELLS_W    = 11;   // cells per axis register
   localparam int PLANE_W    = 2 * CELLS_W;
   localparam int TOTAL_W    = 3 * CELLS_W;
   localparam int INDEX_W    = 30;
   localparam int OFS_W      = 4;
   localparam int CELL_W     = 12;
   localparam int COORD_W    = 34;   // full-precision cell coordinate
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Request kinds
   localparam logic REQ_POS    = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // Register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_GRID_MIN_X = 3'd0,
      REG_GRID_MIN_Y = 3'd1,
      REG_GRID_MIN_Z = 3'd2,
      REG_CELL_EDGE  = 3'd3,
      REG_EDGE_RECIP = 3'd4,
      REG_CELLS_X    = 3'd5,
      REG_CELLS_Y    = 3'd6,
      REG_CELLS_Z    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic                     req_type;
      logic signed [FIX_W-1:0]  point_x;
      logic signed [FIX_W-1:0]  point_y;
      logic signed [FIX_W-1:0]  point_z;
      logic signed [OFS_W-1:0]  neigh_dx;
      logic signed [OFS_W-1:0]  neigh_dy;
      logic signed [OFS_W-1:0]  neigh_dz;
      logic                     clamp_en;
      logic [INDEX_W-1:0]       index_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] cell_x;
      logic signed [CELL_W-1:0] cell_y;
      logic signed [CELL_W-1:0] cell_z;
      logic [INDEX_W-1:0]       linear_index;
      logic                     index_ok;
      logic signed [FIX_W-1:0]  centre_x;
      logic signed [FIX_W-1:0]  centre_y;
      logic signed [FIX_W-1:0]  centre_z;
   } rsp_payload_type;

   // Saturate a full-precision coordinate to the reported cell range
   function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [COORD_W-1:0] v);
      if (v > $signed(COORD_W'(2047)))
         return CELL_W'(2047);
      else if (v < -$signed(COORD_W'(2048)))
         return -$signed(CELL_W'(2048));
      else
         return v[CELL_W-1:0];
   endfunction

   // Saturate a 64-bit value to the signed Q16.16 range
   function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [63:0] v);
      if (v > $signed(64'h0000_0000_7FFF_FFFF))
         return 32'h7FFF_FFFF;
      else if (v < $signed(64'hFFFF_FFFF_8000_0000))
         return 32'h8000_0000;
      else
         return v[FIX_W-1:0];
   endfunction

endpackage

@@ design/uniform_grid_cell_indexer.sv @@
// Uniform grid cell indexer: point to cell index, and index to cell and centre.
// Single-module pipeline; depends on ugci_pkg.
//
//   port group | direction | handshake          | beat
//   req_       | in        | req_valid/req_stall | req_payload_type
//   rsp_       | out       | rsp_valid/rsp_stall | rsp_payload_type
//   csr_       | in        | csr_we              | index csr_addr, data csr_wdata
//
// One beat enters per cycle while the output is not stalled; beats leave in order.
// The depth is set by the index decode: 30 restoring-division stages for the plane
// quotient, 11 for the row quotient, then three for the centre multiply and sum.
// Synchronous reset empties the pipeline and loads the register defaults.
// A stalled output beat freezes the whole pipeline; req_stall follows.
module uniform_grid_cell_indexer #(
   parameter int MAX_AXIS_CELLS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ugci_pkg::req_payload_type    req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ugci_pkg::rsp_payload_type    rsp_data,
   input  logic                         csr_we,
   input  logic [ugci_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ugci_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ugci_pkg::*;

   localparam int ZQ_W    = INDEX_W;               // plane quotient bits
   localparam int YQ_W    = CELLS_W;               // row quotient bits
   localparam int LAT     = ZQ_W + YQ_W + 4;
   localparam int POS_DLY = ZQ_W + YQ_W - 3;

   typedef struct packed {
      logic              neg_x, neg_y, neg_z;
      logic [FIX_W-1:0]  mag_x, mag_y, mag_z;
      logic signed [OFS_W-1:0] dx, dy, dz;
      logic              clamp_en;
   } pos1_type;

   typedef struct packed {
      logic              neg_x, neg_y, neg_z;
      logic [FIX_W-1:0]  q_x, q_y, q_z;
      logic signed [OFS_W-1:0] dx, dy, dz;
      logic              clamp_en;
   } pos2_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x, y, z;
   } pos3_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   x, y, z;
      logic signed [COORD_W+22:0]  mz;
      logic signed [COORD_W+11:0]  my;
   } pos4_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   x, y, z;
      logic signed [COORD_W+23:0]  idx;
   } pos5_type;

   typedef struct packed {
      logic                 req_type;
      logic [INDEX_W-1:0]   idx;
      logic [INDEX_W-1:0]   num;
      logic [PLANE_W-1:0]   rem;
      logic [ZQ_W-1:0]      quot;
   } zdiv_type;

   typedef struct packed {
      logic                 req_type;
      logic [INDEX_W-1:0]   idx;
      logic [ZQ_W-1:0]      z;
      logic [CELLS_W-1:0]   num;
      logic [CELLS_W-1:0]   rem;
      logic [YQ_W-1:0]      quot;
   } ydiv_type;

   typedef struct packed {
      logic                 req_type;
      logic                 ok;
      logic [INDEX_W-1:0]   idx;
      logic [CELLS_W-1:0]   x, y;
      logic [ZQ_W-1:0]      z;
      logic [61:0]          mx, my, mz;
   } cen1_type;

   typedef struct packed {
      logic                 req_type;
      logic                 ok;
      logic [INDEX_W-1:0]   idx;
      logic signed [CELL_W-1:0] cx, cy, cz;
      logic signed [63:0]   tx, ty, tz;
   } cen2_type;

   // Configuration registers and derived grid sizes
   logic signed [FIX_W-1:0] grid_min_x_ff, grid_min_y_ff, grid_min_z_ff;
   logic [EDGE_W-1:0]       cell_edge_ff;
   logic [RECIP_W-1:0]      edge_recip_ff;
   logic [CELLS_W-1:0]      cells_x_ff, cells_y_ff, cells_z_ff;
   logic [CELLS_W-1:0]      ex_ff, ey_ff, ez_ff;
   logic [CELLS_W-1:0]      ex_in, ey_in, ez_in;
   logic [PLANE_W-1:0]      plane_ff, plane_in;
   logic [TOTAL_W-1:0]      total_ff;

   logic                    adv;
   logic                    vld_ff [1:LAT];

   pos1_type        p1_ff, p1_in;
   pos2_type        p2_ff, p2_in;
   pos3_type        p3_ff, p3_in;
   pos4_type        p4_ff, p4_in;
   pos5_type        p5_ff, p5_in;
   rsp_payload_type p6_ff, p6_in;
   rsp_payload_type pdly_ff [0:POS_DLY-1];

   zdiv_type        zd_ff [0:ZQ_W];
   zdiv_type        zd_in [0:ZQ_W];
   ydiv_type        yd_head;
   ydiv_type        yd_src [0:YQ_W-1];
   ydiv_type        yd_ff [1:YQ_W];
   ydiv_type        yd_in [1:YQ_W];
   cen1_type        c1_ff, c1_in;
   cen2_type        c2_ff, c2_in;
   rsp_payload_type out_ff, out_in;

   function automatic logic [CELLS_W-1:0] eff_cells(input logic [CELLS_W-1:0] c);
      if (c == '0)
         return CELLS_W'(1);
      else if (32'(c) > MAX_AXIS_CELLS)
         return CELLS_W'(MAX_AXIS_CELLS);
      else
         return c;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_min_x_ff <= '0;
         grid_min_y_ff <= '0;
         grid_min_z_ff <= '0;
         cell_edge_ff  <= EDGE_W'(65536);
         edge_recip_ff <= RECIP_W'(65536);
         cells_x_ff    <= CELLS_W'(1);
         cells_y_ff    <= CELLS_W'(1);
         cells_z_ff    <= CELLS_W'(1);
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_GRID_MIN_X: grid_min_x_ff <= csr_wdata;
            REG_GRID_MIN_Y: grid_min_y_ff <= csr_wdata;
            REG_GRID_MIN_Z: grid_min_z_ff <= csr_wdata;
            REG_CELL_EDGE:  cell_edge_ff  <= csr_wdata[EDGE_W-1:0];
            REG_EDGE_RECIP: edge_recip_ff <= csr_wdata[RECIP_W-1:0];
            REG_CELLS_X:    cells_x_ff    <= csr_wdata[CELLS_W-1:0];
            REG_CELLS_Y:    cells_y_ff    <= csr_wdata[CELLS_W-1:0];
            REG_CELLS_Z:    cells_z_ff    <= csr_wdata[CELLS_W-1:0];
         endcase
      end
   end

   // Effective cell counts, plane and total size
   always_comb begin
      ex_in    = eff_cells(cells_x_ff);
      ey_in    = eff_cells(cells_y_ff);
      ez_in    = eff_cells(cells_z_ff);
      plane_in = ex_in * ey_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff    <= CELLS_W'(1);
         ey_ff    <= CELLS_W'(1);
         ez_ff    <= CELLS_W'(1);
         plane_ff <= PLANE_W'(1);
         total_ff <= TOTAL_W'(1);
      end else begin
         ex_ff    <= ex_in;
         ey_ff    <= ey_in;
         ez_ff    <= ez_in;
         plane_ff <= plane_in;
         total_ff <= plane_ff * ez_ff;
      end
   end

   // Global advance: hold everything while the output beat is stalled
   assign adv       = !(vld_ff[LAT] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAT];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= req_valid;
         for (int i = 2; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Position path, stage 1: distance from the grid corner as sign and magnitude
   always_comb begin
      logic signed [FIX_W:0] d_x, d_y, d_z;
      d_x = $signed({req_data.point_x[FIX_W-1], req_data.point_x})
          - $signed({grid_min_x_ff[FIX_W-1], grid_min_x_ff});
      d_y = $signed({req_data.point_y[FIX_W-1], req_data.point_y})
          - $signed({grid_min_y_ff[FIX_W-1], grid_min_y_ff});
      d_z = $signed({req_data.point_z[FIX_W-1], req_data.point_z})
          - $signed({grid_min_z_ff[FIX_W-1], grid_min_z_ff});
      p1_in.neg_x    = d_x[FIX_W];
      p1_in.neg_y    = d_y[FIX_W];
      p1_in.neg_z    = d_z[FIX_W];
      p1_in.mag_x    = d_x[FIX_W] ? FIX_W'(-d_x) : d_x[FIX_W-1:0];
      p1_in.mag_y    = d_y[FIX_W] ? FIX_W'(-d_y) : d_y[FIX_W-1:0];
      p1_in.mag_z    = d_z[FIX_W] ? FIX_W'(-d_z) : d_z[FIX_W-1:0];
      p1_in.dx       = req_data.neigh_dx;
      p1_in.dy       = req_data.neigh_dy;
      p1_in.dz       = req_data.neigh_dz;
      p1_in.clamp_en = req_data.clamp_en;
   end

   // Stage 2: scale by the reciprocal, keep the integer part
   always_comb begin
      logic [63:0] pr_x, pr_y, pr_z;
      pr_x = p1_ff.mag_x * edge_recip_ff;
      pr_y = p1_ff.mag_y * edge_recip_ff;
      pr_z = p1_ff.mag_z * edge_recip_ff;
      p2_in.neg_x    = p1_ff.neg_x;
      p2_in.neg_y    = p1_ff.neg_y;
      p2_in.neg_z    = p1_ff.neg_z;
      p2_in.q_x      = pr_x[63:32];
      p2_in.q_y      = pr_y[63:32];
      p2_in.q_z      = pr_z[63:32];
      p2_in.dx       = p1_ff.dx;
      p2_in.dy       = p1_ff.dy;
      p2_in.dz       = p1_ff.dz;
      p2_in.clamp_en = p1_ff.clamp_en;
   end

   // Stage 3: reapply sign, add the neighbor offset, clamp into the grid if clamp_en
   always_comb begin
      logic signed [COORD_W-1:0] s_x, s_y, s_z;
      logic signed [COORD_W-1:0] hi_x, hi_y, hi_z;
      s_x  = $signed({2'b00, p2_ff.q_x});
      s_y  = $signed({2'b00, p2_ff.q_y});
      s_z  = $signed({2'b00, p2_ff.q_z});
      s_x  = (p2_ff.neg_x ? -s_x : s_x) + COORD_W'(p2_ff.dx);
      s_y  = (p2_ff.neg_y ? -s_y : s_y) + COORD_W'(p2_ff.dy);
      s_z  = (p2_ff.neg_z ? -s_z : s_z) + COORD_W'(p2_ff.dz);
      hi_x = $signed({{(COORD_W-CELLS_W){1'b0}}, ex_ff - CELLS_W'(1)});
      hi_y = $signed({{(COORD_W-CELLS_W){1'b0}}, ey_ff - CELLS_W'(1)});
      hi_z = $signed({{(COORD_W-CELLS_W){1'b0}}, ez_ff - CELLS_W'(1)});
      if (p2_ff.clamp_en) begin
         if (s_x < 0) s_x = '0; else if (s_x > hi_x) s_x = hi_x;
         if (s_y < 0) s_y = '0; else if (s_y > hi_y) s_y = hi_y;
         if (s_z < 0) s_z = '0; else if (s_z > hi_z) s_z = hi_z;
      end
      p3_in.x = s_x;
      p3_in.y = s_y;
      p3_in.z = s_z;
   end

   // Stage 4: plane and row products
   always_comb begin
      p4_in.x  = p3_ff.x;
      p4_in.y  = p3_ff.y;
      p4_in.z  = p3_ff.z;
      p4_in.mz = p3_ff.z * $signed({1'b0, plane_ff});
      p4_in.my = p3_ff.y * $signed({1'b0, ex_ff});
   end

   // Stage 5: linear index
   always_comb begin
      p5_in.x   = p4_ff.x;
      p5_in.y   = p4_ff.y;
      p5_in.z   = p4_ff.z;
      p5_in.idx = p4_ff.mz + p4_ff.my + p4_ff.x;
   end

   // Stage 6: range check and position result
   always_comb begin
      logic ok;
      ok = !p5_ff.idx[COORD_W+23]
         && (p5_ff.idx < $signed({{(COORD_W+24-TOTAL_W){1'b0}}, total_ff}))
         && (p5_ff.idx <= $signed({{(COORD_W+24-INDEX_W){1'b0}}, {INDEX_W{1'b1}}}));
      p6_in.cell_x       = sat_cell(p5_ff.x);
      p6_in.cell_y       = sat_cell(p5_ff.y);
      p6_in.cell_z       = sat_cell(p5_ff.z);
      p6_in.linear_index = ok ? p5_ff.idx[INDEX_W-1:0] : '0;
      p6_in.index_ok     = ok;
      p6_in.centre_x     = '0;
      p6_in.centre_y     = '0;
      p6_in.centre_z     = '0;
   end

   // Decode path: restoring division of the index by the plane size
   always_comb begin
      logic [PLANE_W:0] trial;
      zd_in[0].req_type = req_data.req_type;
      zd_in[0].idx      = req_data.index_in;
      zd_in[0].num      = req_data.index_in;
      zd_in[0].rem      = '0;
      zd_in[0].quot     = '0;
      for (int k = 1; k <= ZQ_W; k++) begin
         zd_in[k] = zd_ff[k-1];
         trial    = {zd_ff[k-1].rem, zd_ff[k-1].num[INDEX_W-1]};
         if (trial >= {1'b0, plane_ff}) begin
            trial = trial - {1'b0, plane_ff};
            zd_in[k].quot = {zd_ff[k-1].quot[ZQ_W-2:0], 1'b1};
         end else begin
            zd_in[k].quot = {zd_ff[k-1].quot[ZQ_W-2:0], 1'b0};
         end
         zd_in[k].rem = trial[PLANE_W-1:0];
         zd_in[k].num = {zd_ff[k-1].num[INDEX_W-2:0], 1'b0};
      end
   end

   // Row division: the remainder over cells_x; its quotient fits in YQ_W bits
   always_comb begin
      logic [CELLS_W:0] trial;
      yd_head.req_type = zd_ff[ZQ_W].req_type;
      yd_head.idx      = zd_ff[ZQ_W].idx;
      yd_head.z        = zd_ff[ZQ_W].quot;
      yd_head.rem      = zd_ff[ZQ_W].rem[PLANE_W-1:CELLS_W];
      yd_head.num      = zd_ff[ZQ_W].rem[CELLS_W-1:0];
      yd_head.quot     = '0;
      yd_src[0] = yd_head;
      for (int j = 1; j < YQ_W; j++) yd_src[j] = yd_ff[j];
      for (int j = 1; j <= YQ_W; j++) begin
         yd_in[j] = yd_src[j-1];
         trial    = {yd_src[j-1].rem, yd_src[j-1].num[CELLS_W-1]};
         if (trial >= {1'b0, ex_ff}) begin
            trial = trial - {1'b0, ex_ff};
            yd_in[j].quot = {yd_src[j-1].quot[YQ_W-2:0], 1'b1};
         end else begin
            yd_in[j].quot = {yd_src[j-1].quot[YQ_W-2:0], 1'b0};
         end
         yd_in[j].rem = trial[CELLS_W-1:0];
         yd_in[j].num = {yd_src[j-1].num[CELLS_W-2:0], 1'b0};
      end
   end

   // Centre, step 1: (2c+1) * edge per axis, and the grid range check
   always_comb begin
      c1_in.req_type = yd_ff[YQ_W].req_type;
      c1_in.idx      = yd_ff[YQ_W].idx;
      c1_in.ok       = {{(TOTAL_W-INDEX_W){1'b0}}, yd_ff[YQ_W].idx} < total_ff;
      c1_in.x        = yd_ff[YQ_W].rem;
      c1_in.y        = yd_ff[YQ_W].quot;
      c1_in.z        = yd_ff[YQ_W].z;
      c1_in.mx       = {yd_ff[YQ_W].rem, 1'b1} * cell_edge_ff;
      c1_in.my       = {yd_ff[YQ_W].quot, 1'b1} * cell_edge_ff;
      c1_in.mz       = {yd_ff[YQ_W].z, 1'b1} * cell_edge_ff;
   end

   // Centre, step 2: add twice the grid corner
   always_comb begin
      c2_in.req_type = c1_ff.req_type;
      c2_in.ok       = c1_ff.ok;
      c2_in.idx      = c1_ff.idx;
      c2_in.cx       = sat_cell($signed({{(COORD_W-CELLS_W){1'b0}}, c1_ff.x}));
      c2_in.cy       = sat_cell($signed({{(COORD_W-CELLS_W){1'b0}}, c1_ff.y}));
      c2_in.cz       = sat_cell($signed({{(COORD_W-ZQ_W){1'b0}}, c1_ff.z}));
      c2_in.tx       = $signed({{31{grid_min_x_ff[FIX_W-1]}}, grid_min_x_ff, 1'b0})
                     + $signed({2'b00, c1_ff.mx});
      c2_in.ty       = $signed({{31{grid_min_y_ff[FIX_W-1]}}, grid_min_y_ff, 1'b0})
                     + $signed({2'b00, c1_ff.my});
      c2_in.tz       = $signed({{31{grid_min_z_ff[FIX_W-1]}}, grid_min_z_ff, 1'b0})
                     + $signed({2'b00, c1_ff.mz});
   end

   // Output: halve (floor) and saturate the centre, or pass the position beat
   always_comb begin
      if (c2_ff.req_type == REQ_DECODE) begin
         out_in.cell_x       = c2_ff.cx;
         out_in.cell_y       = c2_ff.cy;
         out_in.cell_z       = c2_ff.cz;
         out_in.linear_index = c2_ff.ok ? c2_ff.idx : '0;
         out_in.index_ok     = c2_ff.ok;
         out_in.centre_x     = sat_fix(c2_ff.tx >>> 1);
         out_in.centre_y     = sat_fix(c2_ff.ty >>> 1);
         out_in.centre_z     = sat_fix(c2_ff.tz >>> 1);
      end else begin
         out_in = pdly_ff[POS_DLY-1];
      end
   end

   // Payload registers: advance together, no reset needed
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         p6_ff  <= p6_in;
         pdly_ff[0] <= p6_ff;
         for (int i = 1; i < POS_DLY; i++) pdly_ff[i] <= pdly_ff[i-1];
         for (int k = 0; k <= ZQ_W; k++) zd_ff[k] <= zd_in[k];
         for (int j = 1; j <= YQ_W; j++) yd_ff[j] <= yd_in[j];
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         out_ff <= out_in;
      end
   end

endmodule

@@ sim/uniform_grid_cell_indexer_tb.sv @@
// Self-checking testbench for uniform_grid_cell_indexer: directed and random
// position and decode beats against an in-bench cell predictor.
// Depends on ugci_pkg and the uniform_grid_cell_indexer RTL.
module uniform_grid_cell_indexer_tb;
   import ugci_pkg::*;

   localparam int MAX_CELLS  = 1024;
   localparam int PIPE_DRAIN = 60;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the grid registers
   logic signed [31:0] min_x, min_y, min_z;
   logic [30:0]        edge_len;
   logic [31:0]        edge_recip;
   logic [10:0]        ncells_x, ncells_y, ncells_z;

   rsp_payload_type cells_pending[$];
   int  mismatches = 0;
   int  stall_left = 0;
   bit  req_burst = 0, rsp_burst = 0;

   uniform_grid_cell_indexer #(.MAX_AXIS_CELLS(MAX_CELLS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint axis_cells(logic [10:0] c);
      if (c == 0) return 1;
      if (c > MAX_CELLS) return MAX_CELLS;
      return longint'(c);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Truncate (p - mn) * recip toward zero
   function automatic longint grid_to_cell(logic signed [31:0] p, logic signed [31:0] mn);
      longint     d;
      logic [63:0] mag, prod;
      d = longint'(p) - longint'(mn);
      mag = d < 0 ? -d : d;
      prod = mag * {32'b0, edge_recip};
      return d < 0 ? -longint'(prod >> 32) : longint'(prod >> 32);
   endfunction

   // Centre = floor((2*min + (2c+1)*edge) / 2), saturated to Q16.16
   function automatic logic [31:0] cell_centre(longint c, logic signed [31:0] mn);
      longint t;
      t = 2 * longint'(mn) + (2 * c + 1) * longint'({1'b0, edge_len});
      t = t >>> 1;
      return 32'(clip(t, -64'sd2147483648, 64'sd2147483647));
   endfunction

   function automatic rsp_payload_type predict_cell(req_payload_type r);
      longint cx, cy, cz, plane, total, x, y, z, idx;
      bit     ok;
      rsp_payload_type o;
      cx = axis_cells(ncells_x);
      cy = axis_cells(ncells_y);
      cz = axis_cells(ncells_z);
      plane = cx * cy;
      total = plane * cz;
      o = '0;
      if (r.req_type == REQ_POS) begin
         x = grid_to_cell(r.point_x, min_x) + longint'(r.neigh_dx);
         y = grid_to_cell(r.point_y, min_y) + longint'(r.neigh_dy);
         z = grid_to_cell(r.point_z, min_z) + longint'(r.neigh_dz);
         if (r.clamp_en) begin
            x = clip(x, 0, cx - 1);
            y = clip(y, 0, cy - 1);
            z = clip(z, 0, cz - 1);
         end
         idx = z * plane + y * cx + x;
         ok = idx >= 0 && idx < total && idx <= 64'h3FFF_FFFF;
      end else begin
         idx = longint'(r.index_in);
         z = idx / plane;
         y = (idx - z * plane) / cx;
         x = idx - z * plane - y * cx;
         ok = idx < total;
         o.centre_x = cell_centre(x, min_x);
         o.centre_y = cell_centre(y, min_y);
         o.centre_z = cell_centre(z, min_z);
      end
      o.cell_x = 12'(clip(x, -2048, 2047));
      o.cell_y = 12'(clip(y, -2048, 2047));
      o.cell_z = 12'(clip(z, -2048, 2047));
      o.linear_index = ok ? 30'(idx) : '0;
      o.index_ok = ok;
      return o;
   endfunction

   // ---------------- result checking ----------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cells_pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat expected none actual %h", $time, rsp_data);
         end else begin
            want = cells_pending.pop_front();
            check_field("cell_x", want.cell_x, rsp_data.cell_x);
            check_field("cell_y", want.cell_y, rsp_data.cell_y);
            check_field("cell_z", want.cell_z, rsp_data.cell_z);
            check_field("linear_index", want.linear_index, rsp_data.linear_index);
            check_field("index_ok", want.index_ok, rsp_data.index_ok);
            check_field("centre_x", want.centre_x, rsp_data.centre_x);
            check_field("centre_y", want.centre_y, rsp_data.centre_y);
            check_field("centre_z", want.centre_z, rsp_data.centre_z);
         end
         stall_left = rsp_burst ? 0 : $urandom_range(0, 11);
      end
   end

   // Hold off the result side for the drawn number of cycles
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else
         rsp_stall = 1'b0;
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_beat(req_payload_type r);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cells_pending = {cells_pending, predict_cell(r)};
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (cells_pending.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      case (idx)
         REG_GRID_MIN_X: min_x = value;
         REG_GRID_MIN_Y: min_y = value;
         REG_GRID_MIN_Z: min_z = value;
         REG_CELL_EDGE:  edge_len = value[30:0];
         REG_EDGE_RECIP: edge_recip = value;
         REG_CELLS_X:    ncells_x = value[10:0];
         REG_CELLS_Y:    ncells_y = value[10:0];
         REG_CELLS_Z:    ncells_z = value[10:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_grid(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                           logic [31:0] e, logic [31:0] rc,
                           logic [10:0] nx, logic [10:0] ny, logic [10:0] nz);
      wait_idle();
      write_reg(REG_GRID_MIN_X, mx);
      write_reg(REG_GRID_MIN_Y, my);
      write_reg(REG_GRID_MIN_Z, mz);
      write_reg(REG_CELL_EDGE, e);
      write_reg(REG_EDGE_RECIP, rc);
      write_reg(REG_CELLS_X, nx);
      write_reg(REG_CELLS_Y, ny);
      write_reg(REG_CELLS_Z, nz);
   endtask

   function automatic req_payload_type pos_beat(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz, logic [3:0] dx,
                                                logic [3:0] dy, logic [3:0] dz, bit cl);
      req_payload_type r;
      r = '0;
      r.req_type = REQ_POS;
      r.point_x = px; r.point_y = py; r.point_z = pz;
      r.neigh_dx = dx; r.neigh_dy = dy; r.neigh_dz = dz;
      r.clamp_en = cl;
      r.index_in = 30'($urandom());
      return r;
   endfunction

   function automatic req_payload_type decode_beat(logic [29:0] idx);
      req_payload_type r;
      r = req_payload_type'({$urandom(), $urandom(), $urandom(), $urandom()});
      r.req_type = REQ_DECODE;
      r.index_in = idx;
      return r;
   endfunction

   function automatic logic [3:0] rand_offset();
      return 4'($signed($urandom_range(0, 8)) - 4);
   endfunction

   // Point on one axis, mostly inside the grid, sometimes a little outside
   function automatic logic [31:0] rand_coord(logic signed [31:0] mn, longint n);
      longint span, v;
      span = n * longint'({1'b0, edge_len});
      v = longint'(mn) + longint'($urandom_range(0, 1000)) * span / 1000;
      if ($urandom_range(0, 9) == 0) v = v - span / 4 + longint'($urandom_range(0, 999)) * span / 2000;
      return 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      send_beat(pos_beat(32'h0, 32'h0, 32'h0, 4'h0, 4'h0, 4'h0, 1'b0));
      send_beat(pos_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 4'h4, 4'hC, 4'h0, 1'b0));
      send_beat(pos_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 4'h4, 4'hC, 4'h3, 1'b1));
      send_beat(decode_beat(30'd0));
      send_beat(decode_beat(30'h3FFF_FFFF));
   endtask

   task automatic test_directed();
      // Out-of-range cell counts: zero acts as one, above the limit clips
      set_grid(32'hFFF0_0000, 32'h0010_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               11'd0, 11'd2047, 11'd1024);
      send_beat(pos_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'hC, 4'h4, 4'h4, 1'b0));
      send_beat(pos_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'hC, 4'h4, 4'h4, 1'b1));
      send_beat(pos_beat(32'h0, 32'h0, 32'h8000_0000, 4'h0, 4'h0, 4'h0, 1'b0));
      send_beat(decode_beat(30'd1023));
      send_beat(decode_beat(30'd1024 * 1024 - 1));
      send_beat(decode_beat(30'h3FFF_FFFF));
      // Zero reciprocal and minimal edge
      set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'h0, 11'd4, 11'd4, 11'd4);
      send_beat(pos_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000, 4'h4, 4'h4, 4'h4, 1'b0));
      send_beat(pos_beat(32'h1234_5678, 32'h0, 32'h0, 4'hC, 4'hC, 4'hC, 1'b0));
      send_beat(decode_beat(30'd63));
      send_beat(decode_beat(30'd64));
      // Unit grid: neighbor offsets run off the edges, clamped and not
      set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 11'd8, 11'd8, 11'd8);
      send_beat(pos_beat(32'h0, 32'h0, 32'h0, 4'hC, 4'hC, 4'hC, 1'b0));
      send_beat(pos_beat(32'h0, 32'h0, 32'h0, 4'hC, 4'hC, 4'hC, 1'b1));
      send_beat(pos_beat(32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, 4'h4, 4'h4, 4'h4, 1'b0));
      send_beat(pos_beat(32'h0007_FFFF, 32'h0007_FFFF, 32'h0007_FFFF, 4'h4, 4'h4, 4'h4, 1'b1));
      send_beat(pos_beat(32'hFFFF_8000, 32'h0000_8000, 32'h0000_0001, 4'h0, 4'h0, 4'h0, 1'b0));
      send_beat(decode_beat(30'd511));
      send_beat(decode_beat(30'd512));
   endtask

   task automatic test_random_phase(int count);
      longint e;
      logic [63:0] rc;
      e = (1 << $urandom_range(10, 22)) + $urandom_range(0, 4095);
      rc = 64'h1_0000_0000 / e;
      set_grid($urandom(), $urandom(), $urandom(), 32'(e), rc[31:0],
               11'($urandom_range(1, 16)), 11'($urandom_range(1, 16)),
               11'($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 2047)));
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            req_burst = $urandom_range(0, 3) == 0;
            rsp_burst = $urandom_range(0, 3) == 0;
         end
         case ($urandom_range(0, 9))
            0: send_beat(pos_beat($urandom(), $urandom(), $urandom(), rand_offset(),
                                  rand_offset(), rand_offset(), 1'($urandom())));
            1: send_beat(decode_beat(30'($urandom())));
            2, 3: send_beat(decode_beat(30'($urandom_range(0,
                    axis_cells(ncells_x) * axis_cells(ncells_y) * axis_cells(ncells_z)))));
            default:
               send_beat(pos_beat(rand_coord(min_x, axis_cells(ncells_x)),
                                  rand_coord(min_y, axis_cells(ncells_y)),
                                  rand_coord(min_z, axis_cells(ncells_z)),
                                  rand_offset(), rand_offset(), rand_offset(),
                                  1'($urandom())));
         endcase
      end
   endtask

   task automatic test_pause_for_drain();
      for (int i = 0; i < 20; i++) begin
         send_beat(decode_beat(30'($urandom_range(0, 300))));
         if (i == 10) wait_idle();
      end
   endtask

   initial begin
      min_x = '0; min_y = '0; min_z = '0;
      edge_len = 31'd65536; edge_recip = 32'd65536;
      ncells_x = 11'd1; ncells_y = 11'd1; ncells_z = 11'd1;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_directed();
      test_pause_for_drain();
      for (int p = 0; p < 14; p++) test_random_phase(100);
      test_random_phase(30);
      wait_idle();
      if (mismatches == 0 && cells_pending.size() == 0)
         $display("uniform_grid_cell_indexer_tb OK");
      else
         $display("uniform_grid_cell_indexer_tb NOT OK");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #2000000;
      $display("uniform_grid_cell_indexer_tb NOT OK");
      $finish;
   end

endmodule

@@ files.f @@
design/ugci_pkg.sv
design/uniform_grid_cell_indexer.sv
sim/uniform_grid_cell_indexer_tb.sv
